### rtl/core/binom_pkg.sv
`default_nettype none
package binom_pkg;

  // Running value and coefficient width (C(34,17) fits in 32 bits).
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned IDX_W  = 6;
  // acc * n never exceeds 32 + 6 bits.
  localparam int unsigned PROD_W = ACC_W + IDX_W;
  localparam int unsigned CNT_W  = 6;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic special;
    logic steps_done;
    logic div_done;
  } dp_sts_t;

endpackage
`default_nettype wire

### rtl/core/binom_ctrl.sv
`default_nettype none
module binom_ctrl
  import binom_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd,
  output logic         busy,
  output logic         done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.special || sts.steps_done) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd.advance = 1'b1;
        state_next  = ST_CHECK;
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/binom_dp.sv
`default_nettype none
module binom_dp
  import binom_pkg::*;
#(
  parameter int unsigned MAX_N = 34
) (
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] n_value,
  input  wire logic [IDX_W-1:0] k_value,
  input  wire dp_cmd_t          cmd,
  output dp_sts_t               sts,
  output logic [ACC_W-1:0]      coefficient,
  output logic                  overflow
);

  logic [ACC_W-1:0]  acc;
  logic [IDX_W-1:0]  n_cur;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  k_reg;
  logic [IDX_W-1:0]  rem;
  logic [PROD_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic              zero_case;
  logic              sat_case;
  logic              ovf;

  logic [PROD_W-1:0] product;
  logic [IDX_W:0]    trial;
  logic              fits;

  assign product = PROD_W'(acc) * PROD_W'(n_cur);
  assign trial   = {rem, quo[PROD_W-1]};
  assign fits    = trial >= {1'b0, idx};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc       <= ACC_W'(1);
      n_cur     <= n_value;
      k_reg     <= k_value;
      idx       <= IDX_W'(1);
      ovf       <= 1'b0;
      zero_case <= k_value > n_value;
      sat_case  <= (k_value <= n_value) && (n_value > IDX_W'(MAX_N));
    end
    if (cmd.mul) begin
      quo <= product;
      rem <= '0;
      cnt <= '0;
    end
    // one restoring step per cycle, divisor is the step index
    if (cmd.div_step) begin
      rem <= fits ? IDX_W'(trial - {1'b0, idx}) : trial[IDX_W-1:0];
      quo <= {quo[PROD_W-2:0], fits};
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.advance) begin
      acc   <= quo[ACC_W-1:0];
      ovf   <= ovf | (|quo[PROD_W-1:ACC_W]);
      n_cur <= n_cur - IDX_W'(1);
      idx   <= idx + IDX_W'(1);
    end
  end

  assign sts.special    = zero_case | sat_case;
  assign sts.steps_done = idx > k_reg;
  assign sts.div_done   = cnt == DIV_LAST;

  always_comb begin
    if (zero_case) begin
      coefficient = '0;
      overflow    = 1'b0;
    end else if (sat_case || ovf) begin
      coefficient = '1;
      overflow    = 1'b1;
    end else begin
      coefficient = acc;
      overflow    = 1'b0;
    end
  end

endmodule
`default_nettype wire

### rtl/core/binomial_coefficient.sv
`default_nettype none
// Channel   Ports                   Handshake
// input     n_value, k_value        word taken when start && !busy
// result    coefficient, overflow   word valid for the one cycle done is high
//
// A job with k > n or n > MAX_N skips the loop; otherwise the loop runs k times.
// Each loop step is a multiply, a restoring divide (one quotient bit per cycle
// over the 38-bit product), an update and a test.
// Reset is synchronous and returns the controller to idle.
// The receiver cannot stall; busy stays high until the result cycle ends.
module binomial_coefficient
  import binom_pkg::*;
#(
  parameter int unsigned MAX_N = 34
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [IDX_W-1:0] n_value,
  input  wire logic [IDX_W-1:0] k_value,
  output logic                  busy,
  output logic                  done,
  output logic [ACC_W-1:0]      coefficient,
  output logic                  overflow
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence the load, multiply, divide and advance commands.
  binom_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Hold the running value; multiply by n, divide exactly by the step index.
  binom_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk         (clk),
    .n_value     (n_value),
    .k_value     (k_value),
    .cmd         (cmd),
    .sts         (sts),
    .coefficient (coefficient),
    .overflow    (overflow)
  );

`ifndef SYNTHESIS
  // A taken word always starts work in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // The result cycle ends the job.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("busy or done held after result");

  // A result only appears while a job is open.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a job");

  // Saturation always drives all ones.
  a_sat_ones: assert property (@(posedge clk) disable iff (rst)
    done && overflow |-> coefficient == '1)
    else $error("overflow without saturated coefficient");
`endif

endmodule
`default_nettype wire
